FILE: sv/wclt_pkg.sv
// ----------------------------------------------------------------------------
// wclt_pkg
// Shared types, field widths and codes of the client learning table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wclt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    // field widths
    localparam int MAC_W   = 48;
    localparam int RSSI_W  = 8;
    localparam int CHAN_W  = 4;
    localparam int FTYPE_W = 2;
    localparam int KIND_W  = 2;
    localparam int INFO_W  = MAC_W + RSSI_W + CHAN_W;

    // header decode constants
    localparam logic [FTYPE_W-1:0] FTYPE_DATA = 2'd2;
    localparam int                 GROUP_BIT  = 40;

    // register reset
    localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 9'd200;

    // input item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_FRAME = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    // result action codes
    typedef enum logic [2:0] {
        ACT_DROP   = 3'd0,
        ACT_UPDATE = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_FULL   = 3'd3,
        ACT_READ   = 3'd4
    } action_t;

    // result source select
    typedef enum logic [2:0] {
        RS_DROP      = 3'd0,
        RS_READ_MISS = 3'd1,
        RS_READ_HIT  = 3'd2,
        RS_UPDATE    = 3'd3,
        RS_INSERT    = 3'd4,
        RS_FULL      = 3'd5
    } res_sel_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_DECODE = 3'd1,
        ST_READ   = 3'd2,
        ST_SEARCH = 3'd3,
        ST_EMIT   = 3'd4
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic     capture;
        logic     rd_req;
        logic     scan_start;
        logic     scan_run;
        logic     clear_count;
        logic     wr_update;
        logic     wr_insert;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  frame_ok;
        logic  read_hit;
        logic  match;
        logic  scan_done;
        logic  room;
    } status_t;

endpackage

`default_nettype wire

FILE: sv/wclt_ram.sv
// ----------------------------------------------------------------------------
// wclt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wclt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/wclt_ctrl.sv
// ----------------------------------------------------------------------------
// wclt_ctrl
// Sequencer: decode, read, linear search and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wclt_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire wclt_pkg::status_t st,
    output wclt_pkg::cmd_t         cmd
);

    wclt_pkg::state_t state_reg;
    wclt_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wclt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wclt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wclt_pkg::ST_DECODE;
                end
            end
            wclt_pkg::ST_DECODE:
            begin
                if (st.kind == wclt_pkg::KIND_READ && st.read_hit)
                begin
                    state_next = wclt_pkg::ST_READ;
                end
                else if (st.kind == wclt_pkg::KIND_FRAME && st.frame_ok)
                begin
                    state_next = wclt_pkg::ST_SEARCH;
                end
                else
                begin
                    state_next = wclt_pkg::ST_EMIT;
                end
            end
            wclt_pkg::ST_READ:
            begin
                state_next = wclt_pkg::ST_EMIT;
            end
            wclt_pkg::ST_SEARCH:
            begin
                if (st.match || st.scan_done)
                begin
                    state_next = wclt_pkg::ST_EMIT;
                end
            end
            wclt_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = wclt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wclt_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd         = '0;
        cmd.res_sel = wclt_pkg::RS_DROP;
        in_ready    = 1'b0;
        unique case (state_reg)
            wclt_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            wclt_pkg::ST_DECODE:
            begin
                unique case (st.kind)
                    wclt_pkg::KIND_CLEAR:
                    begin
                        cmd.clear_count = 1'b1;
                        cmd.res_load    = 1'b1;
                    end
                    wclt_pkg::KIND_READ:
                    begin
                        if (st.read_hit)
                        begin
                            cmd.rd_req = 1'b1;
                        end
                        else
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = wclt_pkg::RS_READ_MISS;
                        end
                    end
                    wclt_pkg::KIND_FRAME:
                    begin
                        if (st.frame_ok)
                        begin
                            cmd.scan_start = 1'b1;
                        end
                        else
                        begin
                            cmd.res_load = 1'b1;
                        end
                    end
                    wclt_pkg::KIND_OTHER:
                    begin
                        cmd.res_load = 1'b1;
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                    end
                endcase
            end
            wclt_pkg::ST_READ:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = wclt_pkg::RS_READ_HIT;
            end
            wclt_pkg::ST_SEARCH:
            begin
                cmd.scan_run = 1'b1;
                // hit wins over end of scan
                priority if (st.match)
                begin
                    cmd.wr_update = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_sel   = wclt_pkg::RS_UPDATE;
                end
                else if (st.scan_done && st.room)
                begin
                    cmd.wr_insert = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_sel   = wclt_pkg::RS_INSERT;
                end
                else if (st.scan_done)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = wclt_pkg::RS_FULL;
                end
                else
                begin
                    cmd.res_load = 1'b0;
                end
            end
            wclt_pkg::ST_EMIT:
            begin
                cmd.out_load = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: sv/wclt_dp.sv
// ----------------------------------------------------------------------------
// wclt_dp
// Datapath: item capture, entry RAMs, scan counter, count and result regs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wclt_dp (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire wclt_pkg::cmd_t                          cmd,
    output wclt_pkg::status_t                            st,
    // config
    input  wire logic                                    cfg_we,
    input  wire logic        [wclt_pkg::CNT_W-1:0]       cfg_data,
    // input fields
    input  wire logic        [wclt_pkg::KIND_W-1:0]      kind,
    input  wire logic                                    pkt_is_data,
    input  wire logic        [wclt_pkg::FTYPE_W-1:0]     frame_type,
    input  wire logic                                    to_ds,
    input  wire logic                                    from_ds,
    input  wire logic        [wclt_pkg::MAC_W-1:0]       addr_one,
    input  wire logic        [wclt_pkg::MAC_W-1:0]       addr_two,
    input  wire logic signed [wclt_pkg::RSSI_W-1:0]      rssi,
    input  wire logic        [wclt_pkg::CHAN_W-1:0]      channel,
    input  wire logic        [wclt_pkg::IDX_W-1:0]       read_index,
    // result fields
    output logic             [2:0]                       action,
    output logic             [wclt_pkg::IDX_W-1:0]       entry_index,
    output logic             [wclt_pkg::CNT_W-1:0]       entry_count,
    output logic             [wclt_pkg::MAC_W-1:0]       station_mac,
    output logic             [wclt_pkg::MAC_W-1:0]       ap_bssid,
    output logic signed      [wclt_pkg::RSSI_W-1:0]      entry_rssi,
    output logic             [wclt_pkg::CHAN_W-1:0]      entry_channel
);

    localparam int IW = wclt_pkg::IDX_W;
    localparam int CW = wclt_pkg::CNT_W;
    localparam int MW = wclt_pkg::MAC_W;
    localparam int RW = wclt_pkg::RSSI_W;
    localparam int HW = wclt_pkg::CHAN_W;
    localparam int NW = wclt_pkg::INFO_W;

    // captured item
    wclt_pkg::kind_t kind_reg;
    logic            frame_ok_reg;
    logic [MW-1:0]   sta_reg;
    logic [MW-1:0]   bss_reg;
    logic [RW-1:0]   rssi_reg;
    logic [HW-1:0]   ch_reg;
    logic [IW-1:0]   ridx_reg;

    logic [MW-1:0]   sta_sel;
    logic            frame_ok_in;

    // control state
    logic [CW-1:0]   max_entries_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [CW-1:0]   scan_addr_reg;
    logic [CW-1:0]   scan_addr_next;
    logic            cmp_valid_reg;
    logic            cmp_valid_next;
    logic [IW-1:0]   cmp_idx_reg;

    // result staging
    wclt_pkg::action_t res_action_reg;
    logic [IW-1:0]     res_idx_reg;
    logic [MW-1:0]     res_sta_reg;
    logic [MW-1:0]     res_bss_reg;
    logic [RW-1:0]     res_rssi_reg;
    logic [HW-1:0]     res_ch_reg;

    // ram signals
    logic            issue;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    logic [MW-1:0]   sta_rd;
    logic [NW-1:0]   info_rd;
    logic            info_we;
    logic [IW-1:0]   wr_addr;
    logic [NW-1:0]   info_wd;

    // station and bssid pick, frame filter
    assign sta_sel     = to_ds ? addr_two : addr_one;
    assign frame_ok_in = pkt_is_data && (frame_type == wclt_pkg::FTYPE_DATA)
                         && (to_ds != from_ds) && !sta_sel[wclt_pkg::GROUP_BIT];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg     <= wclt_pkg::kind_t'(kind);
            frame_ok_reg <= frame_ok_in;
            sta_reg      <= sta_sel;
            bss_reg      <= to_ds ? addr_one : addr_two;
            rssi_reg     <= rssi;
            ch_reg       <= channel;
            ridx_reg     <= read_index;
        end
    end

    // scan issue: one address per cycle, compare in the next cycle
    assign issue   = cmd.scan_run && (scan_addr_reg < count_reg);
    assign rd_en   = cmd.rd_req || issue;
    assign rd_addr = cmd.rd_req ? ridx_reg : scan_addr_reg[IW-1:0];

    always_comb
    begin
        scan_addr_next = scan_addr_reg;
        cmp_valid_next = cmp_valid_reg;
        if (cmd.scan_start)
        begin
            scan_addr_next = '0;
            cmp_valid_next = 1'b0;
        end
        else if (cmd.scan_run)
        begin
            scan_addr_next = scan_addr_reg + CW'(issue);
            cmp_valid_next = issue;
        end
    end

    // station count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (cmd.wr_insert)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= wclt_pkg::MAX_ENTRIES_RESET;
            count_reg       <= '0;
            scan_addr_reg   <= '0;
            cmp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_entries_reg <= cfg_data;
            end
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_run)
        begin
            cmp_idx_reg <= scan_addr_reg[IW-1:0];
        end
    end

    // status to the sequencer
    assign st.kind      = kind_reg;
    assign st.frame_ok  = frame_ok_reg;
    assign st.read_hit  = {1'b0, ridx_reg} < count_reg;
    assign st.match     = cmp_valid_reg && (sta_rd == sta_reg);
    assign st.scan_done = !issue && !cmp_valid_reg;
    assign st.room      = (count_reg < max_entries_reg)
                          && (count_reg < CW'(wclt_pkg::TABLE_DEPTH));

    // entry rams
    assign info_we = cmd.wr_update || cmd.wr_insert;
    assign wr_addr = cmd.wr_insert ? count_reg[IW-1:0] : cmp_idx_reg;
    assign info_wd = {bss_reg, rssi_reg, ch_reg};

    wclt_ram #(
        .WIDTH(MW),
        .DEPTH(wclt_pkg::TABLE_DEPTH)
    ) u_sta_ram (
        .clk    (clk),
        .wr_en  (cmd.wr_insert),
        .wr_addr(wr_addr),
        .wr_data(sta_reg),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(sta_rd)
    );

    wclt_ram #(
        .WIDTH(NW),
        .DEPTH(wclt_pkg::TABLE_DEPTH)
    ) u_info_ram (
        .clk    (clk),
        .wr_en  (info_we),
        .wr_addr(wr_addr),
        .wr_data(info_wd),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(info_rd)
    );

    // result staging
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            unique case (cmd.res_sel)
                wclt_pkg::RS_DROP:
                begin
                    res_action_reg <= wclt_pkg::ACT_DROP;
                    res_idx_reg    <= '0;
                    res_sta_reg    <= '0;
                    res_bss_reg    <= '0;
                    res_rssi_reg   <= '0;
                    res_ch_reg     <= '0;
                end
                wclt_pkg::RS_READ_MISS:
                begin
                    res_action_reg <= wclt_pkg::ACT_DROP;
                    res_idx_reg    <= ridx_reg;
                    res_sta_reg    <= '0;
                    res_bss_reg    <= '0;
                    res_rssi_reg   <= '0;
                    res_ch_reg     <= '0;
                end
                wclt_pkg::RS_READ_HIT:
                begin
                    res_action_reg <= wclt_pkg::ACT_READ;
                    res_idx_reg    <= ridx_reg;
                    res_sta_reg    <= sta_rd;
                    res_bss_reg    <= info_rd[NW-1 -: MW];
                    res_rssi_reg   <= info_rd[HW +: RW];
                    res_ch_reg     <= info_rd[HW-1:0];
                end
                wclt_pkg::RS_UPDATE:
                begin
                    res_action_reg <= wclt_pkg::ACT_UPDATE;
                    res_idx_reg    <= cmp_idx_reg;
                    res_sta_reg    <= sta_reg;
                    res_bss_reg    <= bss_reg;
                    res_rssi_reg   <= rssi_reg;
                    res_ch_reg     <= ch_reg;
                end
                wclt_pkg::RS_INSERT:
                begin
                    res_action_reg <= wclt_pkg::ACT_INSERT;
                    res_idx_reg    <= count_reg[IW-1:0];
                    res_sta_reg    <= sta_reg;
                    res_bss_reg    <= bss_reg;
                    res_rssi_reg   <= rssi_reg;
                    res_ch_reg     <= ch_reg;
                end
                wclt_pkg::RS_FULL:
                begin
                    res_action_reg <= wclt_pkg::ACT_FULL;
                    res_idx_reg    <= '0;
                    res_sta_reg    <= sta_reg;
                    res_bss_reg    <= bss_reg;
                    res_rssi_reg   <= rssi_reg;
                    res_ch_reg     <= ch_reg;
                end
                default:
                begin
                    res_action_reg <= wclt_pkg::ACT_DROP;
                    res_idx_reg    <= '0;
                    res_sta_reg    <= '0;
                    res_bss_reg    <= '0;
                    res_rssi_reg   <= '0;
                    res_ch_reg     <= '0;
                end
            endcase
        end
    end

    // output register, count sampled after the item's update
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            action        <= res_action_reg;
            entry_index   <= res_idx_reg;
            entry_count   <= count_reg;
            station_mac   <= res_sta_reg;
            ap_bssid      <= res_bss_reg;
            entry_rssi    <= res_rssi_reg;
            entry_channel <= res_ch_reg;
        end
    end

endmodule

`default_nettype wire

FILE: sv/wifi_client_learning_table_core.sv
// ----------------------------------------------------------------------------
// wifi_client_learning_table_core
// Learns station to access point pairs from received data frame headers.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               contents
//  in        input      in_valid / in_ready     frame header, read or clear
//  out       output     out_valid / out_ready   one result per item
//  cfg       input      cfg_valid / cfg_ready   max_entries write
//
//  the station search reads one entry per cycle from the station RAM and
//  compares it in the next cycle
//  one item is worked on at a time; the next is taken while a result waits
//  in the output register, and a finished item holds until that register frees
//  reset clears the count and loads the limit with 200; entry RAMs keep their bits
//
`timescale 1ns / 1ps
`default_nettype none

module wifi_client_learning_table_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input channel
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic        [wclt_pkg::KIND_W-1:0]  kind,
    input  wire logic                                pkt_is_data,
    input  wire logic        [wclt_pkg::FTYPE_W-1:0] frame_type,
    input  wire logic                                to_ds,
    input  wire logic                                from_ds,
    input  wire logic        [wclt_pkg::MAC_W-1:0]   addr_one,
    input  wire logic        [wclt_pkg::MAC_W-1:0]   addr_two,
    input  wire logic signed [wclt_pkg::RSSI_W-1:0]  rssi,
    input  wire logic        [wclt_pkg::CHAN_W-1:0]  channel,
    input  wire logic        [wclt_pkg::IDX_W-1:0]   read_index,
    // output channel
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic             [2:0]                   action,
    output logic             [wclt_pkg::IDX_W-1:0]   entry_index,
    output logic             [wclt_pkg::CNT_W-1:0]   entry_count,
    output logic             [wclt_pkg::MAC_W-1:0]   station_mac,
    output logic             [wclt_pkg::MAC_W-1:0]   ap_bssid,
    output logic signed      [wclt_pkg::RSSI_W-1:0]  entry_rssi,
    output logic             [wclt_pkg::CHAN_W-1:0]  entry_channel,
    // configuration channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic        [wclt_pkg::CNT_W-1:0]   cfg_data
);

    wclt_pkg::cmd_t    cmd;
    wclt_pkg::status_t st;
    logic              cfg_we;

    // register writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    wclt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .st       (st),
        .cmd      (cmd)
    );

    wclt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .pkt_is_data  (pkt_is_data),
        .frame_type   (frame_type),
        .to_ds        (to_ds),
        .from_ds      (from_ds),
        .addr_one     (addr_one),
        .addr_two     (addr_two),
        .rssi         (rssi),
        .channel      (channel),
        .read_index   (read_index),
        .action       (action),
        .entry_index  (entry_index),
        .entry_count  (entry_count),
        .station_mac  (station_mac),
        .ap_bssid     (ap_bssid),
        .entry_rssi   (entry_rssi),
        .entry_channel(entry_channel)
    );

    // one item in flight: no transfer right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous item still in work");

    // count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= wclt_pkg::CNT_W'(wclt_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // an insert lands at the last slot
    a_insert_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == wclt_pkg::ACT_INSERT
        |-> entry_count == {1'b0, entry_index} + wclt_pkg::CNT_W'(1))
        else $error("insert index does not match count");

    // reads only return live entries
    a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == wclt_pkg::ACT_READ
        |-> {1'b0, entry_index} < entry_count)
        else $error("read data from an entry beyond the count");

endmodule

`default_nettype wire

FILE: verif/wifi_client_learning_table_core_tb.sv
// ----------------------------------------------------------------------------
// wifi_client_learning_table_core_tb
// Self-checking bench for the station to access point learning table.
// A directed list covers the header decode, group addresses, update, insert,
// full table, reads and clears. Then random phases run under several station
// limits, with table fills, random gaps on both sides and one long output
// stall. A scoreboard class keeps its own copy of the table and compares
// every report field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wifi_client_learning_table_core_tb;

    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 300;
    localparam int POOL_MAX     = 300;

    // one request into the table
    typedef struct packed {
        wclt_pkg::kind_t                  kind;
        logic                             pkt_is_data;
        logic [wclt_pkg::FTYPE_W-1:0]     frame_type;
        logic                             to_ds;
        logic                             from_ds;
        logic [wclt_pkg::MAC_W-1:0]       addr_one;
        logic [wclt_pkg::MAC_W-1:0]       addr_two;
        logic [wclt_pkg::RSSI_W-1:0]      rssi;        // two's complement dBm
        logic [wclt_pkg::CHAN_W-1:0]      channel;
        logic [wclt_pkg::IDX_W-1:0]       read_index;
    } table_req_t;

    // one report out of the table
    typedef struct packed {
        wclt_pkg::action_t                action;
        logic [wclt_pkg::IDX_W-1:0]       entry_index;
        logic [wclt_pkg::CNT_W-1:0]       entry_count;
        logic [wclt_pkg::MAC_W-1:0]       station_mac;
        logic [wclt_pkg::MAC_W-1:0]       ap_bssid;
        logic [wclt_pkg::RSSI_W-1:0]      entry_rssi;
        logic [wclt_pkg::CHAN_W-1:0]      entry_channel;
    } table_rsp_t;

    // shadow table and report scoreboard
    class learning_table_sb;
        logic [wclt_pkg::MAC_W-1:0]  station_mem [wclt_pkg::TABLE_DEPTH];
        logic [wclt_pkg::MAC_W-1:0]  bssid_mem   [wclt_pkg::TABLE_DEPTH];
        logic [wclt_pkg::RSSI_W-1:0] rssi_mem    [wclt_pkg::TABLE_DEPTH];
        logic [wclt_pkg::CHAN_W-1:0] chan_mem    [wclt_pkg::TABLE_DEPTH];
        int unsigned                 count;
        int unsigned                 limit;
        int unsigned                 errors;
        table_rsp_t                  awaited_reports [$];

        function new();
            count  = 0;
            limit  = 32'(wclt_pkg::MAX_ENTRIES_RESET);
            errors = 0;
        endfunction

        function void set_limit(logic [wclt_pkg::CNT_W-1:0] value);
            limit = 32'(value);
        endfunction

        function int unsigned pending();
            return awaited_reports.size();
        endfunction

        // work out the report for an accepted request and update the table
        function void note_header(table_req_t req);
            table_rsp_t                 rsp;
            logic [wclt_pkg::MAC_W-1:0] sta;
            logic [wclt_pkg::MAC_W-1:0] bss;
            int unsigned                slot;
            int unsigned                room;
            bit                         hit;
            rsp    = '0;
            rsp.action = wclt_pkg::ACT_DROP;
            unique case (req.kind)
                wclt_pkg::KIND_READ:
                begin
                    rsp.entry_index = req.read_index;
                    if (32'(req.read_index) < count)
                    begin
                        rsp.action        = wclt_pkg::ACT_READ;
                        rsp.station_mac   = station_mem[req.read_index];
                        rsp.ap_bssid      = bssid_mem[req.read_index];
                        rsp.entry_rssi    = rssi_mem[req.read_index];
                        rsp.entry_channel = chan_mem[req.read_index];
                    end
                end
                wclt_pkg::KIND_CLEAR:
                    count = 0;
                wclt_pkg::KIND_FRAME:
                begin
                    if (req.pkt_is_data && req.frame_type == wclt_pkg::FTYPE_DATA &&
                        req.to_ds != req.from_ds)
                    begin
                        // distribution bits pick which address is the station
                        sta = req.to_ds ? req.addr_two : req.addr_one;
                        bss = req.to_ds ? req.addr_one : req.addr_two;
                        if (!sta[wclt_pkg::GROUP_BIT])
                        begin
                            hit  = 0;
                            slot = 0;
                            for (int unsigned i = 0; i < count; i++)
                            begin
                                if (!hit && station_mem[i] == sta)
                                begin
                                    hit  = 1;
                                    slot = i;
                                end
                            end
                            room = (limit < wclt_pkg::TABLE_DEPTH) ? limit
                                                                   : wclt_pkg::TABLE_DEPTH;
                            if (hit)
                                rsp.action = wclt_pkg::ACT_UPDATE;
                            else if (count < room)
                            begin
                                rsp.action = wclt_pkg::ACT_INSERT;
                                slot       = count;
                                station_mem[slot] = sta;
                                count++;
                            end
                            else
                                rsp.action = wclt_pkg::ACT_FULL;
                            if (rsp.action != wclt_pkg::ACT_FULL)
                            begin
                                bssid_mem[slot]  = bss;
                                rssi_mem[slot]   = req.rssi;
                                chan_mem[slot]   = req.channel;
                                rsp.entry_index  = wclt_pkg::IDX_W'(slot);
                            end
                            rsp.station_mac   = sta;
                            rsp.ap_bssid      = bss;
                            rsp.entry_rssi    = req.rssi;
                            rsp.entry_channel = req.channel;
                        end
                    end
                end
                default: ;
            endcase
            rsp.entry_count = wclt_pkg::CNT_W'(count);
            awaited_reports.push_back(rsp);
        endfunction

        function void report_field(string name, logic [wclt_pkg::MAC_W-1:0] want,
                                   logic [wclt_pkg::MAC_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        // compare a received report with the oldest awaited one
        function void check_report(table_rsp_t got);
            table_rsp_t want;
            if (awaited_reports.size() == 0)
            begin
                errors++;
                $display("%0t: report with none awaited, expected nothing, got action %0d",
                         $time, got.action);
                return;
            end
            want = awaited_reports.pop_front();
            report_field("action", wclt_pkg::MAC_W'(want.action),
                         wclt_pkg::MAC_W'(got.action));
            report_field("entry_index", wclt_pkg::MAC_W'(want.entry_index),
                         wclt_pkg::MAC_W'(got.entry_index));
            report_field("entry_count", wclt_pkg::MAC_W'(want.entry_count),
                         wclt_pkg::MAC_W'(got.entry_count));
            report_field("station_mac", want.station_mac, got.station_mac);
            report_field("ap_bssid", want.ap_bssid, got.ap_bssid);
            report_field("entry_rssi", wclt_pkg::MAC_W'(want.entry_rssi),
                         wclt_pkg::MAC_W'(got.entry_rssi));
            report_field("entry_channel", wclt_pkg::MAC_W'(want.entry_channel),
                         wclt_pkg::MAC_W'(got.entry_channel));
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [wclt_pkg::KIND_W-1:0]   kind;
    logic                          pkt_is_data;
    logic [wclt_pkg::FTYPE_W-1:0]  frame_type;
    logic                          to_ds;
    logic                          from_ds;
    logic [wclt_pkg::MAC_W-1:0]    addr_one;
    logic [wclt_pkg::MAC_W-1:0]    addr_two;
    logic [wclt_pkg::RSSI_W-1:0]   rssi;
    logic [wclt_pkg::CHAN_W-1:0]   channel;
    logic [wclt_pkg::IDX_W-1:0]    read_index;
    logic                          out_valid;
    logic                          out_ready;
    logic [2:0]                    action;
    logic [wclt_pkg::IDX_W-1:0]    entry_index;
    logic [wclt_pkg::CNT_W-1:0]    entry_count;
    logic [wclt_pkg::MAC_W-1:0]    station_mac;
    logic [wclt_pkg::MAC_W-1:0]    ap_bssid;
    logic [wclt_pkg::RSSI_W-1:0]   entry_rssi;
    logic [wclt_pkg::CHAN_W-1:0]   entry_channel;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [wclt_pkg::CNT_W-1:0]    cfg_data;

    learning_table_sb              tables;
    logic [wclt_pkg::MAC_W-1:0]    known_stations [$];
    bit                            no_idle;
    bit                            hold_off_req;
    int unsigned                   quiet_cycles;

    wifi_client_learning_table_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .pkt_is_data   (pkt_is_data),
        .frame_type    (frame_type),
        .to_ds         (to_ds),
        .from_ds       (from_ds),
        .addr_one      (addr_one),
        .addr_two      (addr_two),
        .rssi          (rssi),
        .channel       (channel),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .action        (action),
        .entry_index   (entry_index),
        .entry_count   (entry_count),
        .station_mac   (station_mac),
        .ap_bssid      (ap_bssid),
        .entry_rssi    (entry_rssi),
        .entry_channel (entry_channel),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog on cycles without any transfer
    initial quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // request builders
    function automatic logic [wclt_pkg::MAC_W-1:0] random_mac();
        return wclt_pkg::MAC_W'({$urandom(), $urandom()});
    endfunction

    function automatic table_req_t blank_req(wclt_pkg::kind_t k);
        table_req_t req;
        req      = '0;
        req.kind = k;
        return req;
    endfunction

    function automatic table_req_t read_req(int unsigned idx);
        table_req_t req;
        req            = blank_req(wclt_pkg::KIND_READ);
        req.read_index = wclt_pkg::IDX_W'(idx);
        return req;
    endfunction

    // well-formed data frame, station toward or away from the access point
    function automatic table_req_t good_frame(logic [wclt_pkg::MAC_W-1:0] sta,
                                              logic [wclt_pkg::MAC_W-1:0] bss,
                                              bit to_ap);
        table_req_t req;
        req             = blank_req(wclt_pkg::KIND_FRAME);
        req.pkt_is_data = 1'b1;
        req.frame_type  = wclt_pkg::FTYPE_DATA;
        req.to_ds       = to_ap;
        req.from_ds     = !to_ap;
        req.addr_one    = to_ap ? bss : sta;
        req.addr_two    = to_ap ? sta : bss;
        req.rssi        = wclt_pkg::RSSI_W'($urandom_range(0, 255));
        req.channel     = wclt_pkg::CHAN_W'($urandom_range(0, 15));
        req.read_index  = wclt_pkg::IDX_W'($urandom_range(0, 255));
        return req;
    endfunction

    // new station, now and then a group address
    function automatic logic [wclt_pkg::MAC_W-1:0] fresh_station(bit allow_group);
        logic [wclt_pkg::MAC_W-1:0] mac;
        mac                      = random_mac();
        mac[wclt_pkg::GROUP_BIT] = allow_group && ($urandom_range(0, 19) == 0);
        if (!mac[wclt_pkg::GROUP_BIT])
        begin
            known_stations.push_back(mac);
            if (known_stations.size() > POOL_MAX)
                void'(known_stations.pop_front());
        end
        return mac;
    endfunction

    function automatic table_req_t random_req();
        table_req_t                 req;
        logic [wclt_pkg::MAC_W-1:0] sta;
        int unsigned                pick;
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            if (known_stations.size() != 0 && $urandom_range(0, 99) < 55)
                sta = known_stations[$urandom_range(0, known_stations.size() - 1)];
            else
                sta = fresh_station(1'b1);
            req = good_frame(sta, random_mac(), 1'($urandom_range(0, 1)));
        end
        else if (pick < 82)
        begin
            if (tables.count != 0 && $urandom_range(0, 3) != 0)
                req = read_req($urandom_range(0, tables.count - 1));
            else
                req = read_req($urandom_range(0, 255));
        end
        else if (pick < 83)
            req = blank_req(wclt_pkg::KIND_CLEAR);
        else
        begin
            // noise: malformed headers and the unused kind
            req = good_frame(random_mac(), random_mac(), 1'($urandom_range(0, 1)));
            req.pkt_is_data = 1'($urandom_range(0, 1));
            req.frame_type  = wclt_pkg::FTYPE_W'($urandom_range(0, 3));
            req.to_ds       = 1'($urandom_range(0, 1));
            req.from_ds     = 1'($urandom_range(0, 1));
            if (pick < 86)
                req.kind = wclt_pkg::KIND_OTHER;
        end
        return req;
    endfunction

    // one request transfer, entered and left at a falling edge
    task automatic offer_request(table_req_t req);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind        = req.kind;
        pkt_is_data = req.pkt_is_data;
        frame_type  = req.frame_type;
        to_ds       = req.to_ds;
        from_ds     = req.from_ds;
        addr_one    = req.addr_one;
        addr_two    = req.addr_two;
        rssi        = req.rssi;
        channel     = req.channel;
        read_index  = req.read_index;
        in_valid    = 1'b1;
        do @(posedge clk); while (!in_ready);
        tables.note_header(req);
        @(negedge clk);
    endtask

    // limit write once every awaited report is back
    task automatic write_limit(logic [wclt_pkg::CNT_W-1:0] value);
        in_valid = 1'b0;
        while (tables.pending() != 0)
            @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        tables.set_limit(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic fill_table(int unsigned n);
        repeat (n)
            offer_request(good_frame(fresh_station(1'b0), random_mac(),
                                     1'($urandom_range(0, 1))));
    endtask

    task automatic run_phase(logic [wclt_pkg::CNT_W-1:0] lim, int unsigned fill_n,
                             int unsigned n, bit squeeze);
        write_limit(lim);
        if (fill_n != 0 || $urandom_range(0, 2) != 0)
            offer_request(blank_req(wclt_pkg::KIND_CLEAR));
        fill_table(fill_n);
        if (squeeze)
            hold_off_req = 1'b1;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (i % 64 == 0)
                no_idle = squeeze && i == 0 ? 1'b1 : ($urandom_range(0, 3) == 0);
            offer_request(random_req());
        end
        no_idle = 1'b0;
    endtask

    // directed list: decode, group address, insert, update, full, read, clear
    task automatic directed_checks();
        logic [wclt_pkg::MAC_W-1:0] sta_a;
        logic [wclt_pkg::MAC_W-1:0] sta_b;
        table_req_t                 req;
        sta_a = 48'hFEFF_FFFF_FFFF;
        sta_b = '0;
        offer_request(read_req(0));
        req      = good_frame(sta_a, random_mac(), 1'b1);
        req.kind = wclt_pkg::KIND_OTHER;
        offer_request(req);
        req             = good_frame(sta_a, random_mac(), 1'b1);
        req.pkt_is_data = 1'b0;
        offer_request(req);
        for (int t = 0; t < 4; t++)
        begin
            req            = good_frame(sta_a, random_mac(), 1'b0);
            req.frame_type = wclt_pkg::FTYPE_W'(t);
            if (req.frame_type != wclt_pkg::FTYPE_DATA)
                offer_request(req);
        end
        req       = good_frame(sta_a, random_mac(), 1'b0);
        req.to_ds = 1'b0;
        offer_request(req);
        req         = good_frame(sta_a, random_mac(), 1'b0);
        req.from_ds = 1'b1;
        req.to_ds   = 1'b1;
        offer_request(req);
        offer_request(good_frame(48'h0100_0000_0000, random_mac(), 1'b0));
        req         = good_frame(sta_a, 48'hFFFF_FFFF_FFFF, 1'b1);
        req.rssi    = wclt_pkg::RSSI_W'(-128);
        req.channel = '0;
        offer_request(req);
        req         = good_frame(sta_b, 48'h0, 1'b0);
        req.rssi    = wclt_pkg::RSSI_W'(127);
        req.channel = wclt_pkg::CHAN_W'(15);
        offer_request(req);
        offer_request(good_frame(sta_a, 48'h0123_4567_89AB, 1'b0));
        offer_request(read_req(0));
        offer_request(read_req(1));
        offer_request(read_req(2));
        offer_request(read_req(255));
        // small limits: refused stations, updates still allowed
        write_limit(9'd2);
        offer_request(good_frame(48'h0200_0000_0001, random_mac(), 1'b1));
        write_limit(9'd0);
        offer_request(good_frame(48'h0200_0000_0002, random_mac(), 1'b0));
        offer_request(good_frame(sta_b, random_mac(), 1'b1));
        offer_request(blank_req(wclt_pkg::KIND_CLEAR));
        offer_request(good_frame(sta_a, random_mac(), 1'b1));
        write_limit(9'd1);
        offer_request(good_frame(sta_a, random_mac(), 1'b0));
        offer_request(read_req(0));
    endtask

    // report side: random stalls and one long hold-off
    initial
    begin : report_sink
        table_rsp_t  rsp;
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            rsp.action        = wclt_pkg::action_t'(action);
            rsp.entry_index   = entry_index;
            rsp.entry_count   = entry_count;
            rsp.station_mac   = station_mac;
            rsp.ap_bssid      = ap_bssid;
            rsp.entry_rssi    = entry_rssi;
            rsp.entry_channel = entry_channel;
            tables.check_report(rsp);
            @(negedge clk);
        end
    end

    // main sequence
    initial
    begin
        tables       = new();
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = wclt_pkg::KIND_FRAME;
        pkt_is_data  = 1'b0;
        frame_type   = '0;
        to_ds        = 1'b0;
        from_ds      = 1'b0;
        addr_one     = '0;
        addr_two     = '0;
        rssi         = '0;
        channel      = '0;
        read_index   = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_checks();

        // limits from refusing all to above the table depth
        run_phase(9'd511, 270, 150, 1'b0);
        run_phase(9'd3,     0, 150, 1'b0);
        run_phase(9'd0,     0,  80, 1'b0);
        run_phase(9'd256, 260, 100, 1'b0);
        run_phase(9'd1,     0, 100, 1'b0);
        run_phase(9'd16,    0, 150, 1'b1);
        run_phase(9'd200,   0, 150, 1'b0);
        run_phase(9'd2,     0, 100, 1'b0);
        run_phase(9'd64,    0, 150, 1'b0);

        in_valid = 1'b0;
        while (tables.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (tables.errors == 0 && tables.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
